// File: rtl/rlp_hdr_pkg.sv
// Shared types and constants for the RLP stream header decoder.
package rlp_hdr_pkg;

   localparam int BYTE_W = 8;
   localparam int SIZE_W = 64;
   localparam int HSZ_W  = 4;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [HSZ_W-1:0]  hsz_type;

   typedef enum logic [1:0] {
      KIND_PREFIX,
      KIND_LENGTH,
      KIND_PAYLOAD,
      KIND_LITERAL
   } kind_type;

   typedef enum logic [2:0] {
      ERR_OK,
      ERR_SHORT,
      ERR_MALFORMED,
      ERR_NONCANON,
      ERR_LEAD_ZERO,
      ERR_OVERFLOW
   } err_type;

   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_LENGTH,
      PH_PAYLOAD
   } phase_type;

   // Prefix class boundaries
   localparam byte_type STR_BASE       = 8'h80;
   localparam byte_type SHORT_STR_MAX  = 8'hB7;
   localparam byte_type LONG_STR_MAX   = 8'hBF;
   localparam byte_type LIST_BASE      = 8'hC0;
   localparam byte_type SHORT_LIST_MAX = 8'hF7;
   localparam byte_type RESERVED_LO    = 8'hF9;

   // Long form lengths must exceed the short form range
   localparam size_type MIN_LONG_LEN   = 64'd55;

endpackage

// File: rtl/rlp_hdr_ifs.sv
// Handshake channel interfaces for the RLP stream header decoder.
interface rlp_hdr_req_if;
   logic                  valid;
   logic                  ready;
   rlp_hdr_pkg::byte_type in_byte;
   logic                  in_last;

   modport source (output valid, in_byte, in_last, input ready);
   modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface rlp_hdr_rsp_if;
   logic                  valid;
   logic                  ready;
   rlp_hdr_pkg::byte_type out_byte;
   rlp_hdr_pkg::kind_type byte_kind;
   logic                  header_done;
   logic                  is_list;
   rlp_hdr_pkg::size_type payload_size;
   rlp_hdr_pkg::hsz_type  header_size;
   rlp_hdr_pkg::err_type  error_code;

   modport source (output valid, out_byte, byte_kind, header_done, is_list, payload_size,
                   header_size, error_code, input ready);
   modport sink   (input valid, out_byte, byte_kind, header_done, is_list, payload_size,
                   header_size, error_code, output ready);
endinterface

interface rlp_hdr_csr_if;
   logic                  valid;
   logic                  ready;
   rlp_hdr_pkg::size_type max_payload_size;

   modport source (output valid, max_payload_size, input ready);
   modport sink   (input valid, max_payload_size, output ready);
endinterface

// File: rtl/rlp_stream_header_decoder_core.sv
// RLP stream header decoder: classes one buffer byte per word and reports headers and errors.
//
// Feed the encoded buffer one byte per req word, with in_last set on its final byte; every
// byte yields exactly one rsp word carrying the byte, its kind (prefix, length byte, payload
// byte, literal), and on the byte that completes a header the list flag, payload size and
// header size. The block sustains one byte per clock cycle unless the rsp channel stalls; a
// byte passes an input register, then the decode logic feeding the result register, and the
// per-byte work is a single shift-accumulate and 64-bit compare/decrement. List payloads
// are entered as nested items; the largest count of bytes still owed by any open header is
// kept, so a buffer that ends early reports input too short. The first error sticks: later
// bytes come back with kind prefix, no header and the stuck code until reset. Write
// max_payload_size (reset all ones) on the csr channel only while the block is idle; it
// bounds lengths given in long form. After reset the block is ready at once.
module rlp_stream_header_decoder_core (
   input logic                clock,
   input logic                reset,
   rlp_hdr_req_if.sink        req_if,
   rlp_hdr_rsp_if.source      rsp_if,
   rlp_hdr_csr_if.sink        csr_if
);

   // ---------------------------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------------------------
   rlp_hdr_pkg::size_type max_size_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= '1;
      end else if (csr_if.valid) begin
         max_size_ff <= csr_if.max_payload_size;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Handshake: input register -> decode -> result register
   // ---------------------------------------------------------------------------------------
   logic                  s1_valid_ff;
   rlp_hdr_pkg::byte_type s1_byte_ff;
   logic                  s1_last_ff;
   logic                  rsp_valid_ff;
   logic                  out_free;
   logic                  s1_fire;
   logic                  req_fire;

   // Result register frees up when empty or being taken this cycle
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign s1_fire      = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign req_fire     = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_if.in_byte;
         s1_last_ff <= req_if.in_last;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Parse state
   // ---------------------------------------------------------------------------------------
   rlp_hdr_pkg::phase_type phase_ff;
   logic [3:0]             lbl_ff;      // length bytes still to come
   rlp_hdr_pkg::size_type  acc_ff;      // long form length being gathered
   logic                   pil_ff;      // pending header is a list
   rlp_hdr_pkg::hsz_type   phdr_ff;     // pending header size
   rlp_hdr_pkg::size_type  sbl_ff;      // string payload bytes left
   rlp_hdr_pkg::size_type  owed_ff;     // largest byte count owed by any open header
   logic                   sbc_ff;      // check next byte of a one-byte string
   rlp_hdr_pkg::err_type   sticky_ff;

   // Common per-byte arithmetic
   logic [3:0]            lbl_dec;
   rlp_hdr_pkg::size_type sbl_dec;
   rlp_hdr_pkg::size_type owed_dec;
   rlp_hdr_pkg::size_type acc_next;
   logic                  first_len;

   assign lbl_dec   = lbl_ff - {3'd0, (lbl_ff != 4'd0)};
   assign sbl_dec   = sbl_ff - {63'd0, (sbl_ff != '0)};
   assign owed_dec  = owed_ff - {63'd0, (owed_ff != '0)};
   assign acc_next  = {acc_ff[rlp_hdr_pkg::SIZE_W-rlp_hdr_pkg::BYTE_W-1:0], s1_byte_ff};
   assign first_len = ((lbl_ff + 4'd1) == phdr_ff);

   // ---------------------------------------------------------------------------------------
   // Decode: byte class, header fields and errors raised by this byte
   // ---------------------------------------------------------------------------------------
   rlp_hdr_pkg::kind_type kind;
   logic                  done;
   logic                  lst;
   rlp_hdr_pkg::size_type psz;
   rlp_hdr_pkg::hsz_type  hsz;
   rlp_hdr_pkg::err_type  err_raw;
   logic                  do_open;     // open a payload of size psz
   logic                  do_long;     // start a long form header
   logic [3:0]            long_n;
   logic                  long_list;
   logic                  len_end;     // final length byte seen

   always_comb begin
      kind      = rlp_hdr_pkg::KIND_PREFIX;
      done      = 1'b0;
      lst       = 1'b0;
      psz       = '0;
      hsz       = '0;
      err_raw   = rlp_hdr_pkg::ERR_OK;
      do_open   = 1'b0;
      do_long   = 1'b0;
      long_n    = '0;
      long_list = 1'b0;
      len_end   = 1'b0;
      unique case (phase_ff)
         rlp_hdr_pkg::PH_LENGTH: begin
            kind = rlp_hdr_pkg::KIND_LENGTH;
            if (s1_last_ff && (lbl_dec != 4'd0)) begin
               err_raw = rlp_hdr_pkg::ERR_SHORT;
            end else if (first_len && (s1_byte_ff == '0)) begin
               err_raw = rlp_hdr_pkg::ERR_LEAD_ZERO;
            end else if (lbl_dec == 4'd0) begin
               len_end = 1'b1;
               if (acc_next <= rlp_hdr_pkg::MIN_LONG_LEN) begin
                  err_raw = rlp_hdr_pkg::ERR_NONCANON;
               end else if (acc_next > max_size_ff) begin
                  err_raw = rlp_hdr_pkg::ERR_OVERFLOW;
               end else begin
                  done    = 1'b1;
                  lst     = pil_ff;
                  psz     = acc_next;
                  hsz     = phdr_ff;
                  do_open = 1'b1;
               end
            end
         end
         rlp_hdr_pkg::PH_PAYLOAD: begin
            kind = rlp_hdr_pkg::KIND_PAYLOAD;
            // a one-byte string must not hold a byte that could stand alone
            if (sbc_ff && !s1_byte_ff[7]) begin
               err_raw = rlp_hdr_pkg::ERR_NONCANON;
            end
         end
         default: begin
            if (s1_last_ff && (s1_byte_ff >= rlp_hdr_pkg::RESERVED_LO)) begin
               err_raw = rlp_hdr_pkg::ERR_MALFORMED;
            end else if (!s1_byte_ff[7]) begin
               kind = rlp_hdr_pkg::KIND_LITERAL;
               done = 1'b1;
               psz  = 64'd1;
            end else if (s1_byte_ff <= rlp_hdr_pkg::SHORT_STR_MAX) begin
               done    = 1'b1;
               psz     = {56'd0, s1_byte_ff - rlp_hdr_pkg::STR_BASE};
               hsz     = 4'd1;
               do_open = 1'b1;
            end else if (s1_byte_ff <= rlp_hdr_pkg::LONG_STR_MAX) begin
               do_long = 1'b1;
               long_n  = 4'(s1_byte_ff - rlp_hdr_pkg::SHORT_STR_MAX);
            end else if (s1_byte_ff <= rlp_hdr_pkg::SHORT_LIST_MAX) begin
               done    = 1'b1;
               lst     = 1'b1;
               psz     = {56'd0, s1_byte_ff - rlp_hdr_pkg::LIST_BASE};
               hsz     = 4'd1;
               do_open = 1'b1;
            end else begin
               do_long   = 1'b1;
               long_n    = 4'(s1_byte_ff - rlp_hdr_pkg::SHORT_LIST_MAX);
               long_list = 1'b1;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------------------
   rlp_hdr_pkg::phase_type phase_nx;
   logic [3:0]             lbl_nx;
   rlp_hdr_pkg::size_type  acc_nx;
   logic                   pil_nx;
   rlp_hdr_pkg::hsz_type   phdr_nx;
   rlp_hdr_pkg::size_type  sbl_nx;
   rlp_hdr_pkg::size_type  owed_nx;
   logic                   sbc_nx;

   always_comb begin
      phase_nx = phase_ff;
      lbl_nx   = lbl_ff;
      acc_nx   = acc_ff;
      pil_nx   = pil_ff;
      phdr_nx  = phdr_ff;
      sbl_nx   = sbl_ff;
      owed_nx  = owed_dec;
      sbc_nx   = sbc_ff;
      unique case (phase_ff)
         rlp_hdr_pkg::PH_LENGTH: begin
            lbl_nx = lbl_dec;
            acc_nx = acc_next;
            if (len_end) begin
               phase_nx = rlp_hdr_pkg::PH_PREFIX;
            end
         end
         rlp_hdr_pkg::PH_PAYLOAD: begin
            sbc_nx = 1'b0;
            sbl_nx = sbl_dec;
            if (sbl_dec == '0) begin
               phase_nx = rlp_hdr_pkg::PH_PREFIX;
            end
         end
         default: begin
            phase_nx = rlp_hdr_pkg::PH_PREFIX;
            if (do_open && !lst) begin
               sbc_nx = (psz == 64'd1);
            end
         end
      endcase
      if (do_long) begin
         phase_nx = rlp_hdr_pkg::PH_LENGTH;
         lbl_nx   = long_n;
         phdr_nx  = long_n + 4'd1;
         pil_nx   = long_list;
         acc_nx   = '0;
      end
      if (do_open) begin
         // keep only the largest owed count
         if (psz > owed_dec) begin
            owed_nx = psz;
         end
         if (!lst && (psz != '0)) begin
            phase_nx = rlp_hdr_pkg::PH_PAYLOAD;
            sbl_nx   = psz;
         end
      end
   end

   // Buffer end with bytes still owed or a header half read
   rlp_hdr_pkg::err_type err_fin;
   logic                 clear_parse;

   assign err_fin = (err_raw == rlp_hdr_pkg::ERR_OK && s1_last_ff &&
                     (owed_nx != '0 || phase_nx != rlp_hdr_pkg::PH_PREFIX)) ?
                    rlp_hdr_pkg::ERR_SHORT : err_raw;
   assign clear_parse = s1_last_ff && (err_fin == rlp_hdr_pkg::ERR_OK);

   rlp_hdr_pkg::phase_type phase_in;
   logic [3:0]             lbl_in;
   rlp_hdr_pkg::size_type  acc_in;
   logic                   pil_in;
   rlp_hdr_pkg::hsz_type   phdr_in;
   rlp_hdr_pkg::size_type  sbl_in;
   rlp_hdr_pkg::size_type  owed_in;
   logic                   sbc_in;

   // A clean final byte drops all parse state for the next buffer
   assign phase_in = clear_parse ? rlp_hdr_pkg::PH_PREFIX : phase_nx;
   assign lbl_in   = clear_parse ? '0 : lbl_nx;
   assign acc_in   = clear_parse ? '0 : acc_nx;
   assign pil_in   = clear_parse ? 1'b0 : pil_nx;
   assign phdr_in  = clear_parse ? '0 : phdr_nx;
   assign sbl_in   = clear_parse ? '0 : sbl_nx;
   assign owed_in  = clear_parse ? '0 : owed_nx;
   assign sbc_in   = clear_parse ? 1'b0 : sbc_nx;

   logic parse_en;

   // Hold parse state once an error has stuck
   assign parse_en = s1_fire && (sticky_ff == rlp_hdr_pkg::ERR_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rlp_hdr_pkg::PH_PREFIX;
         lbl_ff    <= '0;
         acc_ff    <= '0;
         pil_ff    <= 1'b0;
         phdr_ff   <= '0;
         sbl_ff    <= '0;
         owed_ff   <= '0;
         sbc_ff    <= 1'b0;
         sticky_ff <= rlp_hdr_pkg::ERR_OK;
      end else if (parse_en) begin
         phase_ff  <= phase_in;
         lbl_ff    <= lbl_in;
         acc_ff    <= acc_in;
         pil_ff    <= pil_in;
         phdr_ff   <= phdr_in;
         sbl_ff    <= sbl_in;
         owed_ff   <= owed_in;
         sbc_ff    <= sbc_in;
         sticky_ff <= err_fin;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------------------------
   rlp_hdr_pkg::byte_type out_byte_ff;
   rlp_hdr_pkg::kind_type kind_ff;
   logic                  done_ff;
   logic                  lst_ff;
   rlp_hdr_pkg::size_type psz_ff;
   rlp_hdr_pkg::hsz_type  hsz_ff;
   rlp_hdr_pkg::err_type  err_ff;
   logic                  hdr_ok;

   // Header fields show only on a clean, completing byte of a live parse
   assign hdr_ok = (sticky_ff == rlp_hdr_pkg::ERR_OK) && (err_fin == rlp_hdr_pkg::ERR_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_byte_ff <= s1_byte_ff;
         if (sticky_ff != rlp_hdr_pkg::ERR_OK) begin
            kind_ff <= rlp_hdr_pkg::KIND_PREFIX;
            err_ff  <= sticky_ff;
         end else begin
            kind_ff <= kind;
            err_ff  <= err_fin;
         end
         done_ff <= hdr_ok && done;
         lst_ff  <= hdr_ok && lst;
         psz_ff  <= hdr_ok ? psz : '0;
         hsz_ff  <= hdr_ok ? hsz : '0;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_byte     = out_byte_ff;
   assign rsp_if.byte_kind    = kind_ff;
   assign rsp_if.header_done  = done_ff;
   assign rsp_if.is_list      = lst_ff;
   assign rsp_if.payload_size = psz_ff;
   assign rsp_if.header_size  = hsz_ff;
   assign rsp_if.error_code   = err_ff;

endmodule
